// File: rtl/imu_serial_frame_decoder_assert.svh
// Assertion macros shared by the IMU frame decoder modules.
// Needs nothing else; each macro takes the clock and active-low reset to use.
`ifndef IMU_SERIAL_FRAME_DECODER_ASSERT_SVH
`define IMU_SERIAL_FRAME_DECODER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ISFD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("imu frame decoder check failed");

// Consequent must hold in the cycle after the antecedent.
`define ISFD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("imu frame decoder check failed");

`endif

// File: rtl/isfd_pkg.sv
// Types, constants and scaling functions for the IMU serial frame decoder.
// Used by the frame tracker, the scaler and the top level; depends on nothing.
`default_nettype none

package isfd_pkg;

  localparam int unsigned AXIS_W = 25;
  localparam int unsigned TEMP_W = 17;

  // frame bytes
  localparam logic [7:0] HDR_BYTE   = 8'h55;
  localparam logic [7:0] TYPE_ACC   = 8'h51;
  localparam logic [7:0] TYPE_RATE  = 8'h52;
  localparam logic [7:0] TYPE_ANGLE = 8'h53;

  // frame kinds
  localparam logic [1:0] KIND_ACC   = 2'd0;
  localparam logic [1:0] KIND_RATE  = 2'd1;
  localparam logic [1:0] KIND_ANGLE = 2'd2;

  // byte positions within a frame
  localparam logic [3:0] POS_HUNT      = 4'd0;
  localparam logic [3:0] POS_TYPE      = 4'd1;
  localparam logic [3:0] POS_DATA0     = 4'd2;
  localparam logic [3:0] POS_DATA_LAST = 4'd9;
  localparam logic [3:0] POS_LAST      = 4'd10;

  // axis gains, 13 fraction bits: 16*8192/32768, 2000*8192/32768, 180*8192/32768
  localparam logic signed [AXIS_W-1:0] RATE_GAIN  = 25'sd500;
  localparam logic signed [AXIS_W-1:0] ANGLE_GAIN = 25'sd45;

  // temperature: round(raw*64/85) + 9280, done as floor((raw*64 + BIAS)/85) - OFFSET
  localparam logic [23:0] TEMP_BIAS   = 24'd2097247;  // 85*24673 + 42
  localparam logic [23:0] TEMP_RECIP  = 24'd12632257; // ceil(2^30/85)
  localparam logic [16:0] TEMP_OFFSET = 17'd15393;    // 24673 - 9280
  localparam logic signed [TEMP_W-1:0] TEMP_MIN = -17'sd15392;
  localparam logic signed [TEMP_W-1:0] TEMP_MAX = 17'sd33952;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [15:0] raw_x;
    logic signed [15:0] raw_y;
    logic signed [15:0] raw_z;
    logic signed [15:0] raw_t;
  } frame_t;

  function automatic logic signed [AXIS_W-1:0] scale_axis(input logic signed [15:0] raw,
                                                          input logic [1:0] kind);
    logic signed [AXIS_W-1:0] ext;
    logic signed [AXIS_W-1:0] res;
    ext = AXIS_W'(raw);
    case (kind)
      KIND_ACC:  res = ext <<< 2;
      KIND_RATE: res = ext * RATE_GAIN;
      default:   res = ext * ANGLE_GAIN;
    endcase
    return res;
  endfunction

  function automatic logic signed [TEMP_W-1:0] scale_temp(input logic signed [15:0] raw);
    logic [23:0] biased;
    logic [22:0] num;
    logic [46:0] prod;
    logic [15:0] quo;
    // biased value is always positive and below 2^23
    biased = {{2{raw[15]}}, raw, 6'b0} + TEMP_BIAS;
    num    = biased[22:0];
    prod   = 47'(num) * 47'(TEMP_RECIP);
    quo    = prod[45:30];
    return TEMP_W'(17'(quo) - TEMP_OFFSET);
  endfunction

endpackage

`default_nettype wire

// File: rtl/imu_serial_frame_decoder.sv
// IMU 11-byte serial frame decoder: one received byte per beat, one result per frame.
// The result is in the output register in the cycle after the eleventh byte is accepted.
// Throughput: one byte per cycle; in_stall rises only for an eleventh byte while the
// previous result is still held and stalled in the output register.
// Reset (rst_n low, synchronous) returns to header hunt and empties the output register.
// Built from isfd_tracker and isfd_scaler; depends on isfd_pkg.
`default_nettype none

module imu_serial_frame_decoder (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic [7:0]                         in_rx_byte,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic [1:0]                              out_frame_kind,
  output logic signed [isfd_pkg::AXIS_W-1:0]      out_axis_x,
  output logic signed [isfd_pkg::AXIS_W-1:0]      out_axis_y,
  output logic signed [isfd_pkg::AXIS_W-1:0]      out_axis_z,
  output logic signed [isfd_pkg::TEMP_W-1:0]      out_temperature
);

  isfd_pkg::frame_t frame;
  logic             last_byte;
  logic             accept;
  logic             load;

  // hold the closing beat only while the result slot is full and blocked
  assign in_stall = last_byte && out_valid && out_stall;
  assign accept   = in_valid && !in_stall;
  assign load     = accept && last_byte;

  isfd_tracker u_tracker (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .rx_byte   (in_rx_byte),
    .frame     (frame),
    .last_byte (last_byte)
  );

  isfd_scaler u_scaler (
    .clk             (clk),
    .rst_n           (rst_n),
    .load            (load),
    .frame           (frame),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .out_frame_kind  (out_frame_kind),
    .out_axis_x      (out_axis_x),
    .out_axis_y      (out_axis_y),
    .out_axis_z      (out_axis_z),
    .out_temperature (out_temperature)
  );

endmodule

`default_nettype wire

// File: rtl/isfd_tracker.sv
// Frame tracker: header hunt, type check, byte position and data byte store.
// Depends on isfd_pkg and the decoder assertion macros.
`default_nettype none
`include "imu_serial_frame_decoder_assert.svh"

module isfd_tracker (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          accept,
  input  wire logic [7:0]    rx_byte,
  output isfd_pkg::frame_t   frame,
  output logic               last_byte
);

  logic [3:0] pos_r;
  logic [3:0] pos_nxt;
  logic [1:0] kind_r;
  logic [1:0] kind_nxt;
  logic [7:0] payload_r [8];
  logic       wr_en;
  logic [2:0] wr_idx;

  assign last_byte = (pos_r == isfd_pkg::POS_LAST);
  assign wr_idx    = 3'(pos_r - isfd_pkg::POS_DATA0);

  always_comb begin
    pos_nxt  = pos_r;
    kind_nxt = kind_r;
    wr_en    = 1'b0;
    if (accept) begin
      case (pos_r)
        isfd_pkg::POS_TYPE: begin
          if (rx_byte == isfd_pkg::TYPE_ACC || rx_byte == isfd_pkg::TYPE_RATE ||
              rx_byte == isfd_pkg::TYPE_ANGLE) begin
            kind_nxt = 2'(rx_byte - isfd_pkg::TYPE_ACC);
            pos_nxt  = isfd_pkg::POS_DATA0;
          end else if (rx_byte == isfd_pkg::HDR_BYTE) begin
            // bad type that is itself a header: start over from here
            pos_nxt = isfd_pkg::POS_TYPE;
          end else begin
            pos_nxt = isfd_pkg::POS_HUNT;
          end
        end
        isfd_pkg::POS_LAST: begin
          // checksum byte: taken, never checked
          pos_nxt = isfd_pkg::POS_HUNT;
        end
        default: begin
          if (pos_r >= isfd_pkg::POS_DATA0 && pos_r <= isfd_pkg::POS_DATA_LAST) begin
            wr_en   = 1'b1;
            pos_nxt = pos_r + 4'd1;
          end else begin
            pos_nxt = (rx_byte == isfd_pkg::HDR_BYTE) ? isfd_pkg::POS_TYPE
                                                      : isfd_pkg::POS_HUNT;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= isfd_pkg::POS_HUNT;
      kind_r <= isfd_pkg::KIND_ACC;
    end else begin
      pos_r  <= pos_nxt;
      kind_r <= kind_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      payload_r[wr_idx] <= rx_byte;
    end
  end

  assign frame.kind  = kind_r;
  assign frame.raw_x = {payload_r[1], payload_r[0]};
  assign frame.raw_y = {payload_r[3], payload_r[2]};
  assign frame.raw_z = {payload_r[5], payload_r[4]};
  assign frame.raw_t = {payload_r[7], payload_r[6]};

  `ISFD_ASSERT_NEXT(a_last_returns_to_hunt, clk, rst_n, accept && last_byte,
                    pos_r == isfd_pkg::POS_HUNT)
  `ISFD_ASSERT_NOW(a_pos_in_range, clk, rst_n, 1'b1, pos_r <= isfd_pkg::POS_LAST)
  `ISFD_ASSERT_NOW(a_kind_in_range, clk, rst_n, 1'b1, kind_r <= isfd_pkg::KIND_ANGLE)

endmodule

`default_nettype wire

// File: rtl/isfd_scaler.sv
// Scaler and result register: axis gains and temperature conversion of one frame.
// Depends on isfd_pkg and the decoder assertion macros.
`default_nettype none
`include "imu_serial_frame_decoder_assert.svh"

module isfd_scaler (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               load,
  input  wire isfd_pkg::frame_t                   frame,
  input  wire logic                               out_stall,
  output logic                                    out_valid,
  output logic [1:0]                              out_frame_kind,
  output logic signed [isfd_pkg::AXIS_W-1:0]      out_axis_x,
  output logic signed [isfd_pkg::AXIS_W-1:0]      out_axis_y,
  output logic signed [isfd_pkg::AXIS_W-1:0]      out_axis_z,
  output logic signed [isfd_pkg::TEMP_W-1:0]      out_temperature
);

  logic                                 valid_r;
  logic                                 valid_nxt;
  logic [1:0]                           kind_r;
  logic signed [isfd_pkg::AXIS_W-1:0]   x_r;
  logic signed [isfd_pkg::AXIS_W-1:0]   y_r;
  logic signed [isfd_pkg::AXIS_W-1:0]   z_r;
  logic signed [isfd_pkg::TEMP_W-1:0]   temp_r;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (valid_r && !out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind_r <= frame.kind;
      x_r    <= isfd_pkg::scale_axis(frame.raw_x, frame.kind);
      y_r    <= isfd_pkg::scale_axis(frame.raw_y, frame.kind);
      z_r    <= isfd_pkg::scale_axis(frame.raw_z, frame.kind);
      temp_r <= isfd_pkg::scale_temp(frame.raw_t);
    end
  end

  assign out_valid       = valid_r;
  assign out_frame_kind  = kind_r;
  assign out_axis_x      = x_r;
  assign out_axis_y      = y_r;
  assign out_axis_z      = z_r;
  assign out_temperature = temp_r;

  `ISFD_ASSERT_NEXT(a_load_shows_result, clk, rst_n, load, valid_r)
  `ISFD_ASSERT_NOW(a_no_overwrite, clk, rst_n, load, !(valid_r && out_stall))
  `ISFD_ASSERT_NOW(a_temp_range, clk, rst_n, valid_r,
                   temp_r >= isfd_pkg::TEMP_MIN && temp_r <= isfd_pkg::TEMP_MAX)

endmodule

`default_nettype wire
